// ----- hdl/bmw_pkg.sv -----
// Package for the binary morphology window: sizes, register codes, geometry struct
// and helpers that turn raw register values into the values the datapath uses.
// No dependencies; used by bmw_csr, bmw_cell and the top level.
`default_nettype none
package bmw_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_KSIZE  = 7;

   localparam int DIM_W  = 12;
   localparam int KS_W   = 3;
   localparam int RAD_W  = 2;
   localparam int MASK_W = 49;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
   localparam int LAG_W  = $clog2((MAX_KSIZE / 2) * MAX_WIDTH + (MAX_KSIZE / 2) + 1);
   localparam int TAPS   = MAX_KSIZE;
   localparam int LINE_W = MAX_KSIZE - 1;
   localparam int WIN_W  = TAPS * TAPS;

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   localparam int OFIFO_DEPTH = 4;
   localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
   localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
   localparam logic [PIX_W-1:0] PIX_ONE  = 8'd1;
   localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_KSIZE  = 3'd2,
      REG_MASK   = 3'd3,
      REG_OP     = 3'd4,
      REG_SCALE  = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
      logic [LAG_W-1:0] lag;
      logic [WIN_W-1:0] tap_mask;
      logic             erode;
      logic             full_scale;
   } geom_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw, input int limit);
      logic [DIM_W-1:0] d;
      d = raw;
      if (raw == '0) begin
         d = DIM_W'(1);
      end else if (raw > DIM_W'(limit)) begin
         d = DIM_W'(limit);
      end
      return d;
   endfunction

   function automatic logic [KS_W-1:0] eff_ksize(input logic [KS_W-1:0] raw);
      logic [KS_W-1:0] k;
      k = raw;
      if (k > KS_W'(MAX_KSIZE)) begin
         k = KS_W'(MAX_KSIZE);
      end
      if (!k[0]) begin
         k = (k > KS_W'(1)) ? k - KS_W'(1) : KS_W'(1);
      end
      return k;
   endfunction

   // r*W + r, with r at most 3
   function automatic logic [LAG_W-1:0] lag_of(input logic [RAD_W-1:0] rad,
                                                input logic [DIM_W-1:0] w);
      logic [LAG_W-1:0] l;
      l = LAG_W'(rad);
      if (rad[0]) begin
         l = l + LAG_W'(w);
      end
      if (rad[1]) begin
         l = l + (LAG_W'(w) << 1);
      end
      return l;
   endfunction

   // Mask in tap coordinates: bit t*TAPS+b is tap t (column age), row age b.
   function automatic logic [WIN_W-1:0] tap_mask(input logic [MASK_W-1:0] m,
                                                  input logic [KS_W-1:0] k);
      logic [WIN_W-1:0] g;
      int r2;
      int i;
      int j;
      g  = '0;
      r2 = int'(k >> 1) * 2;
      for (int t = 0; t < TAPS; t++) begin
         for (int b = 0; b < TAPS; b++) begin
            i = r2 - b;
            j = r2 - t;
            if (i >= 0 && j >= 0) begin
               g[t*TAPS+b] = m[i*int'(k)+j];
            end
         end
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/bmw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bmw_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/bmw_cell.sv -----
// One window column cell: holds a column of the newest rows, passes it on to the
// next older column on each push, and reduces its masked bits. Uses bmw_pkg.
`default_nettype none
module bmw_cell (
   input  wire logic                     clock,
   input  wire logic                     shift_en,
   input  wire logic [bmw_pkg::TAPS-1:0] col_in,
   output logic      [bmw_pkg::TAPS-1:0] col_out,
   input  wire logic [bmw_pkg::TAPS-1:0] tap_mask,
   input  wire logic [bmw_pkg::TAPS-1:0] row_ok,
   input  wire logic                     col_ok,
   output logic                          or_part,
   output logic                          and_part
);

   logic [bmw_pkg::TAPS-1:0] col_ff;
   logic [bmw_pkg::TAPS-1:0] bits;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      bits     = col_ff & row_ok & {bmw_pkg::TAPS{col_ok}};
      or_part  = |(bits & tap_mask);
      and_part = &(bits | ~tap_mask);
   end

   assign col_out = col_ff;

endmodule
`default_nettype wire

// ----- hdl/bmw_csr.sv -----
// Configuration registers on an APB-style port, plus the derived geometry
// (clamped sizes, radius, lag, mask in tap order). Uses bmw_pkg.
`default_nettype none
module bmw_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [bmw_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [bmw_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [bmw_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready,
   output bmw_pkg::geom_type                 geo,
   output logic                              geo_clear
);

   logic [bmw_pkg::DIM_W-1:0]  width_ff, height_ff;
   logic [bmw_pkg::KS_W-1:0]   ksize_ff;
   logic [bmw_pkg::MASK_W-1:0] mask_ff;
   logic                       op_ff, scale_ff;
   logic [bmw_pkg::DIM_W-1:0]  effw_ff, effh_ff;
   logic [bmw_pkg::KS_W-1:0]   effk_ff;
   logic [bmw_pkg::RAD_W-1:0]  rad_ff;
   logic [bmw_pkg::LAG_W-1:0]  lag_ff;
   logic [bmw_pkg::WIN_W-1:0]  tmask_ff;

   logic                      wr;
   bmw_pkg::reg_idx_type      idx;
   logic [bmw_pkg::DIM_W-1:0] new_w, new_h;
   logic [bmw_pkg::KS_W-1:0]  new_k;
   logic [bmw_pkg::RAD_W-1:0] new_r;

   assign wr    = csr_psel & csr_penable & csr_pwrite;
   assign idx   = bmw_pkg::reg_idx_type'(csr_paddr[bmw_pkg::CSR_AW-1:3]);
   assign new_w = bmw_pkg::eff_dim(csr_pwdata[bmw_pkg::DIM_W-1:0], bmw_pkg::MAX_WIDTH);
   assign new_h = bmw_pkg::eff_dim(csr_pwdata[bmw_pkg::DIM_W-1:0], bmw_pkg::MAX_HEIGHT);
   assign new_k = bmw_pkg::eff_ksize(csr_pwdata[bmw_pkg::KS_W-1:0]);
   assign new_r = bmw_pkg::RAD_W'(new_k >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmw_pkg::DIM_W'(640);
         height_ff <= bmw_pkg::DIM_W'(480);
         ksize_ff  <= bmw_pkg::KS_W'(3);
         mask_ff   <= bmw_pkg::MASK_W'(511);
         op_ff     <= 1'b0;
         scale_ff  <= 1'b1;
         effw_ff   <= bmw_pkg::DIM_W'(640);
         effh_ff   <= bmw_pkg::DIM_W'(480);
         effk_ff   <= bmw_pkg::KS_W'(3);
         rad_ff    <= bmw_pkg::RAD_W'(1);
         lag_ff    <= bmw_pkg::LAG_W'(641);
         tmask_ff  <= bmw_pkg::tap_mask(bmw_pkg::MASK_W'(511), bmw_pkg::KS_W'(3));
      end else if (wr) begin
         unique case (idx)
            bmw_pkg::REG_WIDTH: begin
               width_ff <= csr_pwdata[bmw_pkg::DIM_W-1:0];
               effw_ff  <= new_w;
               lag_ff   <= bmw_pkg::lag_of(rad_ff, new_w);
            end
            bmw_pkg::REG_HEIGHT: begin
               height_ff <= csr_pwdata[bmw_pkg::DIM_W-1:0];
               effh_ff   <= new_h;
            end
            bmw_pkg::REG_KSIZE: begin
               ksize_ff <= csr_pwdata[bmw_pkg::KS_W-1:0];
               effk_ff  <= new_k;
               rad_ff   <= new_r;
               lag_ff   <= bmw_pkg::lag_of(new_r, effw_ff);
               tmask_ff <= bmw_pkg::tap_mask(mask_ff, new_k);
            end
            bmw_pkg::REG_MASK: begin
               mask_ff  <= csr_pwdata[bmw_pkg::MASK_W-1:0];
               tmask_ff <= bmw_pkg::tap_mask(csr_pwdata[bmw_pkg::MASK_W-1:0], effk_ff);
            end
            bmw_pkg::REG_OP: begin
               op_ff <= csr_pwdata[0];
            end
            bmw_pkg::REG_SCALE: begin
               scale_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bmw_pkg::REG_WIDTH:  csr_prdata = bmw_pkg::CSR_DW'(width_ff);
         bmw_pkg::REG_HEIGHT: csr_prdata = bmw_pkg::CSR_DW'(height_ff);
         bmw_pkg::REG_KSIZE:  csr_prdata = bmw_pkg::CSR_DW'(ksize_ff);
         bmw_pkg::REG_MASK:   csr_prdata = bmw_pkg::CSR_DW'(mask_ff);
         bmw_pkg::REG_OP:     csr_prdata = bmw_pkg::CSR_DW'(op_ff);
         bmw_pkg::REG_SCALE:  csr_prdata = bmw_pkg::CSR_DW'(scale_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign geo_clear = wr && (idx == bmw_pkg::REG_WIDTH || idx == bmw_pkg::REG_HEIGHT ||
                             idx == bmw_pkg::REG_KSIZE);
   assign csr_pready = 1'b1;

   always_comb begin
      geo.width      = effw_ff;
      geo.height     = effh_ff;
      geo.radius     = rad_ff;
      geo.lag        = lag_ff;
      geo.tap_mask   = tmask_ff;
      geo.erode      = op_ff;
      geo.full_scale = scale_ff;
   end

endmodule
`default_nettype wire

// ----- hdl/binary_morphology_window.sv -----
// Binary morphology window: streaming dilation/erosion of a raster binary frame.
// Top level; uses bmw_pkg, bmw_csr, bmw_ram and bmw_cell.
//
// Usage:
//  - req_* carries one beat per pixel (tuser = 0, bit 0 of tdata used) or a flush
//    tick (tuser = 1). rsp_* returns result pixels, tlast on the frame's final one.
//  - Configure over csr_* only while the block is idle; a write of width, height or
//    kernel size restarts frame counting.
//  - With r = kernel_size/2, output pixel n is produced by input beat n + r*W + r;
//    once the frame is in, each flush (or extra pixel) beat yields one more output.
//  - When the frame is smaller than r*W + r, the block goes on shifting in padding
//    after the frame's last pixel until its lag count reaches r*W + r, with req_tready low.
//  - Throughput: one beat per cycle while req_tready is high. A result passes stage 1
//    (line RAM read) and stage 2 (window cells) before it enters the output queue.
//  - The line RAM holds six rows per column; one read and one write per beat set
//    the rate. A row of seven column cells forms the window.
//  - A four-entry output queue absorbs rsp_tready stalls; req_tready drops once
//    four results are outstanding.
//  - Reset is synchronous and clears the counters and queue; the line RAM needs no
//    clearing, since rows outside the frame are masked off.
`default_nettype none
module binary_morphology_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] pixel
   input  wire logic                          req_tuser,   // [0] kind
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [7:0]                    rsp_tdata,   // [7:0] pixel_out
   output logic                               rsp_tlast,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bmw_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [bmw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [bmw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int TAPS = bmw_pkg::TAPS;

   bmw_pkg::geom_type geo;
   logic              geo_clear;

   bmw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geo         (geo),
      .geo_clear   (geo_clear)
   );

   // ---------------- input side: position counters ----------------
   logic [bmw_pkg::COL_W-1:0]     in_col_ff, in_col_in;
   logic [bmw_pkg::ROW_W-1:0]     in_row_ff, in_row_in;
   logic [bmw_pkg::COL_W-1:0]     out_col_ff, out_col_in;
   logic [bmw_pkg::COL_W-1:0]     out_row_ff, out_row_in;
   logic [bmw_pkg::LAG_W-1:0]     lag_cnt_ff, lag_cnt_in;
   logic [bmw_pkg::OFIFO_CW-1:0]  pend_ff, pend_in;

   logic in_done, lag_full, catchup, acc, push, emit, last_now, pop;
   logic in_col_wrap, out_col_wrap;

   assign in_done  = in_row_ff >= geo.height;
   assign lag_full = lag_cnt_ff == geo.lag;
   assign catchup  = in_done && !lag_full;
   assign req_tready = !catchup && (pend_ff < bmw_pkg::OFIFO_CW'(bmw_pkg::OFIFO_DEPTH));
   assign acc  = req_tvalid && req_tready;
   assign push = catchup || (acc && (in_done || !req_tuser));
   assign emit = acc && (in_done || (!req_tuser && lag_full));
   assign in_col_wrap  = ({1'b0, in_col_ff} + bmw_pkg::DIM_W'(1)) == geo.width;
   assign out_col_wrap = ({1'b0, out_col_ff} + bmw_pkg::DIM_W'(1)) == geo.width;
   assign last_now = out_col_wrap &&
                     ({1'b0, out_row_ff} + bmw_pkg::DIM_W'(1)) == geo.height;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_cnt_in = lag_cnt_ff;
      if (push) begin
         if (in_col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + bmw_pkg::ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + bmw_pkg::COL_W'(1);
         end
         if (!lag_full) begin
            lag_cnt_in = lag_cnt_ff + bmw_pkg::LAG_W'(1);
         end
      end
      if (emit) begin
         if (out_col_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + bmw_pkg::COL_W'(1);
         end else begin
            out_col_in = out_col_ff + bmw_pkg::COL_W'(1);
         end
      end
      if ((emit && last_now) || geo_clear) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_cnt_ff <= '0;
         pend_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_cnt_ff <= lag_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   assign pend_in = pend_ff + bmw_pkg::OFIFO_CW'(emit) - bmw_pkg::OFIFO_CW'(pop);

   // ---------------- stage 1: line RAM read, column build ----------------
   logic                          s1_push_ff, s1_emit_ff, s1_last_ff, s1_px_ff, s1_fwd_ff;
   logic [bmw_pkg::COL_W-1:0]     s1_col_ff, s1_oy_ff, s1_ox_ff;
   logic [bmw_pkg::LINE_W-1:0]    wr_last_ff;
   logic [bmw_pkg::LINE_W-1:0]    ram_rd;
   logic [TAPS-1:0]               col_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_push_ff <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else begin
         s1_push_ff <= push;
         s1_emit_ff <= emit;
      end
      s1_last_ff <= last_now;
      s1_px_ff   <= !in_done && req_tdata[0];
      s1_fwd_ff  <= s1_push_ff && (s1_col_ff == in_col_ff);
      s1_col_ff  <= in_col_ff;
      s1_oy_ff   <= out_row_ff;
      s1_ox_ff   <= out_col_ff;
      if (s1_push_ff) begin
         wr_last_ff <= col_vec[bmw_pkg::LINE_W-1:0];
      end
   end

   bmw_ram #(
      .WIDTH (bmw_pkg::LINE_W),
      .DEPTH (bmw_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_push_ff),
      .wr_addr (s1_col_ff),
      .wr_data (col_vec[bmw_pkg::LINE_W-1:0]),
      .rd_en   (push),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd)
   );

   // bit 0 is the newest row, bit b is b rows older
   assign col_vec = {(s1_fwd_ff ? wr_last_ff : ram_rd), s1_px_ff};

   // frame bounds of the window, in tap order
   logic [bmw_pkg::DIM_W-1:0] cy, cx;
   logic [bmw_pkg::DIM_W:0]   dy, dx;
   logic [TAPS-1:0]           row_ok, col_ok;

   always_comb begin
      cy = {1'b0, s1_oy_ff} + bmw_pkg::DIM_W'(geo.radius);
      cx = {1'b0, s1_ox_ff} + bmw_pkg::DIM_W'(geo.radius);
      dy = '0;
      dx = '0;
      for (int b = 0; b < TAPS; b++) begin
         dy        = {1'b0, cy} - (bmw_pkg::DIM_W + 1)'(b);
         dx        = {1'b0, cx} - (bmw_pkg::DIM_W + 1)'(b);
         row_ok[b] = (cy >= bmw_pkg::DIM_W'(b)) && (dy < {1'b0, geo.height});
         col_ok[b] = (cx >= bmw_pkg::DIM_W'(b)) && (dx < {1'b0, geo.width});
      end
   end

   // ---------------- stage 2: window cells and reduction ----------------
   logic                  s2_emit_ff, s2_last_ff;
   logic [TAPS-1:0]       s2_rowok_ff, s2_colok_ff;
   logic [TAPS-1:0]       cell_col [TAPS];
   logic [TAPS-1:0]       or_parts, and_parts;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
      s2_last_ff  <= s1_last_ff;
      s2_rowok_ff <= row_ok;
      s2_colok_ff <= col_ok;
   end

   for (genvar t = 0; t < TAPS; t++) begin : g_cell
      logic [TAPS-1:0] cin;
      if (t == 0) begin : g_head
         assign cin = col_vec;
      end else begin : g_link
         assign cin = cell_col[t-1];
      end
      bmw_cell u_cell (
         .clock    (clock),
         .shift_en (s1_push_ff),
         .col_in   (cin),
         .col_out  (cell_col[t]),
         .tap_mask (geo.tap_mask[t*TAPS +: TAPS]),
         .row_ok   (s2_rowok_ff),
         .col_ok   (s2_colok_ff[t]),
         .or_part  (or_parts[t]),
         .and_part (and_parts[t])
      );
   end

   logic             win_hit;
   logic [7:0]       pix_res;

   assign win_hit = geo.erode ? &and_parts : |or_parts;
   assign pix_res = !win_hit ? bmw_pkg::PIX_ZERO :
                    (geo.full_scale ? bmw_pkg::PIX_FULL : bmw_pkg::PIX_ONE);

   // ---------------- output queue ----------------
   logic [8:0]                   ofifo_ff [bmw_pkg::OFIFO_DEPTH];
   logic [bmw_pkg::OFIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bmw_pkg::OFIFO_CW-1:0] ocnt_ff, ocnt_in;

   assign pop     = rsp_tvalid && rsp_tready;
   assign ocnt_in = ocnt_ff + bmw_pkg::OFIFO_CW'(s2_emit_ff) - bmw_pkg::OFIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         ocnt_ff   <= '0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (s2_emit_ff) begin
            wr_ptr_ff <= wr_ptr_ff + bmw_pkg::OFIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bmw_pkg::OFIFO_AW'(1);
         end
      end
      if (s2_emit_ff) begin
         ofifo_ff[wr_ptr_ff] <= {s2_last_ff, pix_res};
      end
   end

   assign rsp_tvalid = ocnt_ff != '0;
   assign rsp_tdata  = ofifo_ff[rd_ptr_ff][7:0];
   assign rsp_tlast  = ofifo_ff[rd_ptr_ff][8];

   // ---------------- checks ----------------
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= bmw_pkg::OFIFO_CW'(bmw_pkg::OFIFO_DEPTH))
      else $error("outstanding results exceed queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_emit_ff |-> (ocnt_ff != bmw_pkg::OFIFO_CW'(bmw_pkg::OFIFO_DEPTH) || pop))
      else $error("output queue written while full");

   a_queue_le_pend: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= pend_ff)
      else $error("queue holds more than outstanding count");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (emit && last_now) |=> (out_row_ff == '0 && out_col_ff == '0 &&
                              in_row_ff == '0 && lag_cnt_ff == '0))
      else $error("counters not cleared after final pixel");

endmodule
`default_nettype wire
